// ===== rtl/sao_pkg.sv =====
// Shared types, constants and helper functions for the sprite alpha overlay.
// No dependencies; every other file of the block except sao_ram imports this package.

package sao_pkg;

   // Sprite store geometry
   localparam int SPRITE_W_MAX = 64;
   localparam int SPRITE_H_MAX = 64;
   localparam int STORE_DEPTH  = SPRITE_W_MAX * SPRITE_H_MAX;
   localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int COL_W        = (SPRITE_W_MAX > 1) ? $clog2(SPRITE_W_MAX) : 1;
   localparam int ROW_W        = (SPRITE_H_MAX > 1) ? $clog2(SPRITE_H_MAX) : 1;

   // Field widths
   localparam int POS_W       = 12;
   localparam int OFFSET_W    = 13;
   localparam int SIZE_W      = 7;
   localparam int FRAME_W     = 14;   // signed pos - offset
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 4;
   localparam int PIXEL_W     = CHAN_W * NUM_CHAN;
   localparam int SUM_W       = 2 * CHAN_W;
   localparam int CSR_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int ALPHA_CHAN  = 3;

   typedef logic [CHAN_W-1:0]          chan_type;
   typedef chan_type [NUM_CHAN-1:0]    pixel_type;
   typedef logic [SUM_W-1:0]           sum_type;
   typedef sum_type [NUM_CHAN-1:0]     sum_vec_type;

   localparam chan_type         ALPHA_MAX    = 8'd255;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 7'd64;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_BLEND = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_X      = 2'd0,
      CSR_OFFSET_Y      = 2'd1,
      CSR_SPRITE_WIDTH  = 2'd2,
      CSR_SPRITE_HEIGHT = 2'd3
   } csr_index_type;

   // Control that travels with a blend request down the pipe
   typedef struct packed {
      logic valid;
      logic covered;
   } stage_ctl_type;

   // floor(x / 255) for x <= 255*255
   function automatic chan_type div255(input sum_type x);
      logic [SUM_W:0] t;
      t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[SUM_W-1:CHAN_W]} + {{SUM_W{1'b0}}, 1'b1};
      return t[SUM_W-1:CHAN_W];
   endfunction

endpackage

// ===== rtl/sao_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on sao_pkg.

interface sao_req_if import sao_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   chan_type         chan_0;
   chan_type         chan_1;
   chan_type         chan_2;
   chan_type         chan_3;

   modport source (output valid, kind, pos_x, pos_y, chan_0, chan_1, chan_2, chan_3,
                   input ready);
   modport sink   (input valid, kind, pos_x, pos_y, chan_0, chan_1, chan_2, chan_3,
                   output ready);
endinterface

interface sao_rsp_if import sao_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type out_0;
   chan_type out_1;
   chan_type out_2;
   chan_type out_3;
   logic     covered;

   modport source (output valid, out_0, out_1, out_2, out_3, covered, input ready);
   modport sink   (input valid, out_0, out_1, out_2, out_3, covered, output ready);
endinterface

// ===== rtl/sao_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.

module sao_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sao_locate.sv =====
// Front of the pipe: window position, sprite store write and read.
// Depends on sao_pkg and sao_ram.

module sao_locate import sao_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic                in_kind,
   input  logic [POS_W-1:0]    pos_x,
   input  logic [POS_W-1:0]    pos_y,
   input  pixel_type           in_pix,
   input  logic [OFFSET_W-1:0] offset_x,
   input  logic [OFFSET_W-1:0] offset_y,
   input  logic [SIZE_W-1:0]   sprite_width,
   input  logic [SIZE_W-1:0]   sprite_height,
   output stage_ctl_type       ctl_out,
   output pixel_type           dst_pix,
   output pixel_type           spr_pix
);

   // stage 1: frame-relative position
   logic                s1_valid_ff;
   logic                s1_blend_ff;
   logic [POS_W-1:0]    s1_pos_x_ff;
   logic [POS_W-1:0]    s1_pos_y_ff;
   logic [FRAME_W-1:0]  s1_fx_ff;
   logic [FRAME_W-1:0]  s1_fy_ff;
   pixel_type           s1_pix_ff;
   logic [FRAME_W-1:0]  fx_in;
   logic [FRAME_W-1:0]  fy_in;

   // stage 2: coverage, store access
   logic                s2_valid_ff;
   logic                s2_covered_ff;
   pixel_type           s2_pix_ff;
   logic                fx_ok;
   logic                fy_ok;
   logic                load_ok;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [PIXEL_W-1:0]  rd_data;

   // modular subtract gives the two's complement difference
   assign fx_in = {{(FRAME_W-POS_W){1'b0}}, pos_x} - {offset_x[OFFSET_W-1], offset_x};
   assign fy_in = {{(FRAME_W-POS_W){1'b0}}, pos_y} - {offset_y[OFFSET_W-1], offset_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
      if (adv) begin
         s1_blend_ff <= (in_kind == KIND_BLEND);
         s1_pos_x_ff <= pos_x;
         s1_pos_y_ff <= pos_y;
         s1_fx_ff    <= fx_in;
         s1_fy_ff    <= fy_in;
         s1_pix_ff   <= in_pix;
      end
   end

   // size above the store maximum saturates; negative fails on the sign bit
   assign fx_ok = !s1_fx_ff[FRAME_W-1]
                  && (s1_fx_ff < {{(FRAME_W-SIZE_W){1'b0}}, sprite_width})
                  && (s1_fx_ff < FRAME_W'(SPRITE_W_MAX));
   assign fy_ok = !s1_fy_ff[FRAME_W-1]
                  && (s1_fy_ff < {{(FRAME_W-SIZE_W){1'b0}}, sprite_height})
                  && (s1_fy_ff < FRAME_W'(SPRITE_H_MAX));

   assign load_ok = (s1_pos_x_ff < POS_W'(SPRITE_W_MAX))
                    && (s1_pos_y_ff < POS_W'(SPRITE_H_MAX));

   assign wr_en   = adv && s1_valid_ff && !s1_blend_ff && load_ok;
   assign wr_addr = ADDR_W'(s1_pos_y_ff[ROW_W-1:0]) * ADDR_W'(SPRITE_W_MAX)
                    + ADDR_W'(s1_pos_x_ff[COL_W-1:0]);
   assign rd_addr = ADDR_W'(s1_fy_ff[ROW_W-1:0]) * ADDR_W'(SPRITE_W_MAX)
                    + ADDR_W'(s1_fx_ff[COL_W-1:0]);

   sao_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s1_pix_ff),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // loads end here
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_blend_ff;
      end
      if (adv) begin
         s2_covered_ff <= fx_ok && fy_ok;
         s2_pix_ff     <= s1_pix_ff;
      end
   end

   assign ctl_out.valid   = s2_valid_ff;
   assign ctl_out.covered = s2_covered_ff;
   assign dst_pix         = s2_pix_ff;
   assign spr_pix         = pixel_type'(rd_data);

endmodule

// ===== rtl/sao_blend.sv =====
// Back of the pipe: per-channel products, then divide by 255 and select.
// Depends on sao_pkg.

module sao_blend import sao_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  stage_ctl_type ctl_in,
   input  pixel_type     dst_pix,
   input  pixel_type     spr_pix,
   output stage_ctl_type ctl_out,
   output pixel_type     res_pix
);

   // stage 3
   logic          s3_valid_ff;
   logic          s3_covered_ff;
   logic          s3_mix_ff;
   pixel_type     s3_dst_ff;
   sum_vec_type   s3_sum_ff;
   sum_vec_type   sum_in;
   chan_type      alpha;
   chan_type      alpha_inv;

   // stage 4
   logic          s4_valid_ff;
   logic          s4_covered_ff;
   pixel_type     s4_pix_ff;
   pixel_type     pix_in;

   assign alpha     = spr_pix[ALPHA_CHAN];
   assign alpha_inv = ALPHA_MAX - alpha;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         sum_in[i] = SUM_W'(dst_pix[i]) * SUM_W'(alpha_inv)
                     + SUM_W'(spr_pix[i]) * SUM_W'(alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= ctl_in.valid;
      end
      if (adv) begin
         s3_covered_ff <= ctl_in.covered;
         s3_mix_ff     <= ctl_in.covered && (alpha != '0);
         s3_dst_ff     <= dst_pix;
         s3_sum_ff     <= sum_in;
      end
   end

   // zero alpha or outside the window: destination passes unchanged
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         pix_in[i] = s3_mix_ff ? div255(s3_sum_ff[i]) : s3_dst_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_covered_ff <= s3_covered_ff;
         s4_pix_ff     <= pix_in;
      end
   end

   assign ctl_out.valid   = s4_valid_ff;
   assign ctl_out.covered = s4_covered_ff;
   assign res_pix         = s4_pix_ff;

endmodule

// ===== rtl/sao_outbuf.sv =====
// Response output register with one skid entry; full stalls the pipe.
// Depends on sao_pkg and sao_rsp_if.

module sao_outbuf import sao_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_covered,
   input  pixel_type        in_pix,
   output logic             full,
   sao_rsp_if.source        rsp_bus
);

   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_cov_ff;
   logic      out_cov_in;
   pixel_type out_pix_ff;
   pixel_type out_pix_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   logic      skid_cov_ff;
   logic      skid_cov_in;
   pixel_type skid_pix_ff;
   pixel_type skid_pix_in;
   logic      take;

   assign take = out_valid_ff && rsp_bus.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_cov_in    = out_cov_ff;
      out_pix_in    = out_pix_ff;
      skid_valid_in = skid_valid_ff;
      skid_cov_in   = skid_cov_ff;
      skid_pix_in   = skid_pix_ff;
      if (skid_valid_ff) begin
         // pipe is frozen while skid holds a response
         if (take) begin
            out_cov_in    = skid_cov_ff;
            out_pix_in    = skid_pix_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_cov_in   = in_covered;
            out_pix_in   = in_pix;
         end else begin
            skid_valid_in = 1'b1;
            skid_cov_in   = in_covered;
            skid_pix_in   = in_pix;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_cov_ff  <= out_cov_in;
      out_pix_ff  <= out_pix_in;
      skid_cov_ff <= skid_cov_in;
      skid_pix_ff <= skid_pix_in;
   end

   assign full            = skid_valid_ff;
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.out_0   = out_pix_ff[0];
   assign rsp_bus.out_1   = out_pix_ff[1];
   assign rsp_bus.out_2   = out_pix_ff[2];
   assign rsp_bus.out_3   = out_pix_ff[3];
   assign rsp_bus.covered = out_cov_ff;

endmodule

// ===== rtl/sprite_alpha_overlay_unit.sv =====
// Sprite alpha overlay top level: CSRs, pipeline and response buffer.
// Depends on sao_pkg, sao_if, sao_locate, sao_blend, sao_outbuf.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  req_bus  | in  | valid/ready        | kind, pos_x, pos_y, chan_0..chan_3
//  rsp_bus  | out | valid/ready        | out_0..out_3, covered
//  csr_*    | in  | csr_wr_en (no ack) | csr_index, csr_wdata
//
// One request per clock sustained while the skid entry is empty. A blend
// request passes stages 1 to 4 into the response register; a load request
// yields no response and is written into the sprite store from stage 1.
// Stages: offset subtract, window compare + store read, multiply-add,
// divide by 255 + select. Sync active-high reset clears valid bits and offset
// CSRs, sets sprite sizes to 64; the sprite store is not cleared. A stalled
// response parks in a skid entry, which holds the pipe and req_bus.ready low.

module sprite_alpha_overlay_unit import sao_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   sao_req_if.sink                req_bus,
   sao_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   logic [OFFSET_W-1:0] offset_x_ff;
   logic [OFFSET_W-1:0] offset_y_ff;
   logic [SIZE_W-1:0]   sprite_width_ff;
   logic [SIZE_W-1:0]   sprite_height_ff;

   logic                adv;
   logic                full;
   logic                accept;
   pixel_type           req_pix;
   stage_ctl_type       loc_ctl;
   pixel_type           loc_dst;
   pixel_type           loc_spr;
   stage_ctl_type       blend_ctl;
   pixel_type           blend_pix;

   // CSRs: the user must write them only while the block is idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff      <= '0;
         offset_y_ff      <= '0;
         sprite_width_ff  <= SIZE_RESET;
         sprite_height_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OFFSET_X:      offset_x_ff      <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_Y:      offset_y_ff      <= csr_wdata[OFFSET_W-1:0];
            CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: the whole pipe moves unless the skid entry is taken
   assign adv           = !full;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;

   assign req_pix[0] = req_bus.chan_0;
   assign req_pix[1] = req_bus.chan_1;
   assign req_pix[2] = req_bus.chan_2;
   assign req_pix[3] = req_bus.chan_3;

   sao_locate u_locate (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (accept),
      .in_kind       (req_bus.kind),
      .pos_x         (req_bus.pos_x),
      .pos_y         (req_bus.pos_y),
      .in_pix        (req_pix),
      .offset_x      (offset_x_ff),
      .offset_y      (offset_y_ff),
      .sprite_width  (sprite_width_ff),
      .sprite_height (sprite_height_ff),
      .ctl_out       (loc_ctl),
      .dst_pix       (loc_dst),
      .spr_pix       (loc_spr)
   );

   sao_blend u_blend (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (loc_ctl),
      .dst_pix (loc_dst),
      .spr_pix (loc_spr),
      .ctl_out (blend_ctl),
      .res_pix (blend_pix)
   );

   // leaving the pipe only on an advance, so no response is sent twice
   sao_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (blend_ctl.valid && adv),
      .in_covered (blend_ctl.covered),
      .in_pix     (blend_pix),
      .full       (full),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTHESIS
   // skid entry is only ever used behind a held response
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      full |-> rsp_bus.valid)
      else $error("skid entry occupied with empty response register");

   // skid entry drains only when the response register is taken
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !rsp_bus.ready) |=> full)
      else $error("skid entry lost while response stalled");

   // no request is taken while the pipe is frozen
   a_no_accept_frozen: assert property (@(posedge clock) disable iff (reset)
      full |-> !(req_bus.valid && req_bus.ready))
      else $error("request accepted while pipe frozen");
`endif

endmodule
